>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the emphasis filter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define AEF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define AEF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/aef_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aef_pkg
// Types, widths, register map and fixed-point helpers of the emphasis filter.
// ---------------------------------------------------------------------------
package aef_pkg;

   // Sample and state formats
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int GAIN_FRAC   = 13;
   localparam int STATE_BITS  = SAMPLE_BITS + FRAC_BITS;
   localparam int COEF_BITS   = 16;
   localparam int SUBSTEPS_BITS = 5;

   // Multiplier operand, product and rounded result widths
   localparam int OPA_BITS  = STATE_BITS + 3;
   localparam int PROD_BITS = OPA_BITS + COEF_BITS + 1;
   localparam int RES_BITS  = PROD_BITS - GAIN_FRAC;
   localparam int ACC_BITS  = STATE_BITS + 8;

   localparam int HALF_FRAC = 1 << (FRAC_BITS - 1);
   localparam int HALF_GAIN = 1 << (GAIN_FRAC - 1);

   localparam int MAX_SUBSTEPS_DEF = 16;

   // Register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_MODE       = 3'd0,
      REG_COEF_X     = 3'd1,
      REG_COEF_POINT = 3'd2,
      REG_STEP_SCALE = 3'd3,
      REG_SUBSTEPS   = 3'd4,
      REG_OUT_GAIN   = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic                     mode;
      logic [COEF_BITS-1:0]     coef_x;
      logic [COEF_BITS-1:0]     coef_point;
      logic [COEF_BITS-1:0]     step_scale;
      logic [SUBSTEPS_BITS-1:0] substeps;
      logic [COEF_BITS-1:0]     out_gain;
   } aef_cfg_type;

   localparam aef_cfg_type CFG_RESET = '{
      mode:       1'b0,
      coef_x:     16'd3716,
      coef_point: 16'd32211,
      step_scale: 16'd8192,
      substeps:   5'd8,
      out_gain:   16'd2458
   };

   // Which coefficient the shared multiplier takes, and so its rounding point
   typedef enum logic [1:0] {
      COEF_STEP,
      COEF_X,
      COEF_POINT,
      COEF_GAIN
   } coef_sel_type;

   // Request and result payloads
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_end;
   } aef_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          block_end_out;
   } aef_rsp_type;

   // Sign-extend a state value to accumulator width
   function automatic logic signed [ACC_BITS-1:0] ext_state(
      input logic signed [STATE_BITS-1:0] v);
      return {{(ACC_BITS-STATE_BITS){v[STATE_BITS-1]}}, v};
   endfunction

   // Sign-extend a multiplier operand to accumulator width
   function automatic logic signed [ACC_BITS-1:0] ext_opa(
      input logic signed [OPA_BITS-1:0] v);
      return {{(ACC_BITS-OPA_BITS){v[OPA_BITS-1]}}, v};
   endfunction

   // Sign-extend a rounded product to accumulator width
   function automatic logic signed [ACC_BITS-1:0] ext_res(
      input logic signed [RES_BITS-1:0] v);
      return {{(ACC_BITS-RES_BITS){v[RES_BITS-1]}}, v};
   endfunction

   // Clamp an accumulator value to the state range
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_BITS-1:0] v);
      logic [ACC_BITS-STATE_BITS:0] top_bits;
      top_bits = v[ACC_BITS-1:STATE_BITS-1];
      if (top_bits == '0 || top_bits == '1) begin
         return v[STATE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         return {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_BITS-1){1'b1}}};
      end
   endfunction

   // Round to nearest at the binary point, ties upward
   function automatic logic signed [ACC_BITS-1:0] rnd_frac(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] s;
      s = v + ACC_BITS'(HALF_FRAC);
      return s >>> FRAC_BITS;
   endfunction

   // Clamp an integer accumulator value to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_BITS-1:0] v);
      logic [ACC_BITS-SAMPLE_BITS:0] top_bits;
      top_bits = v[ACC_BITS-1:SAMPLE_BITS-1];
      if (top_bits == '0 || top_bits == '1) begin
         return v[SAMPLE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

endpackage

>>> hdl/aef_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aef_csr
// APB-style register file holding the filter mode and coefficients.
// ---------------------------------------------------------------------------
module aef_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [aef_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [aef_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [aef_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output aef_pkg::aef_cfg_type                 cfg
);
   import aef_pkg::*;

   aef_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign cfg     = cfg_ff;

   // Decode the write; unknown indices drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MODE:       cfg_in.mode       = pwdata[0];
            REG_COEF_X:     cfg_in.coef_x     = pwdata[COEF_BITS-1:0];
            REG_COEF_POINT: cfg_in.coef_point = pwdata[COEF_BITS-1:0];
            REG_STEP_SCALE: cfg_in.step_scale = pwdata[COEF_BITS-1:0];
            REG_SUBSTEPS:   cfg_in.substeps   = pwdata[SUBSTEPS_BITS-1:0];
            REG_OUT_GAIN:   cfg_in.out_gain   = pwdata[COEF_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_MODE:       prdata = CSR_DATA_BITS'(cfg_ff.mode);
         REG_COEF_X:     prdata = CSR_DATA_BITS'(cfg_ff.coef_x);
         REG_COEF_POINT: prdata = CSR_DATA_BITS'(cfg_ff.coef_point);
         REG_STEP_SCALE: prdata = CSR_DATA_BITS'(cfg_ff.step_scale);
         REG_SUBSTEPS:   prdata = CSR_DATA_BITS'(cfg_ff.substeps);
         REG_OUT_GAIN:   prdata = CSR_DATA_BITS'(cfg_ff.out_gain);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/aef_mul_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aef_mul_unit
// Shared two-stage multiply and round unit: product, then rounded shift.
// ---------------------------------------------------------------------------
module aef_mul_unit (
   input  logic                                   clock,
   input  aef_pkg::aef_cfg_type                   cfg,
   input  aef_pkg::coef_sel_type                  coef_sel,
   input  logic signed [aef_pkg::OPA_BITS-1:0]    opa,
   output logic signed [aef_pkg::RES_BITS-1:0]    res
);
   import aef_pkg::*;

   logic        [COEF_BITS-1:0] coef;
   logic signed [COEF_BITS:0]   coef_s;
   logic signed [PROD_BITS-1:0] prod_in, prod_ff;
   logic                        gain_in, gain_ff;
   logic signed [PROD_BITS-1:0] biased;
   logic signed [PROD_BITS-1:0] shifted;
   logic signed [RES_BITS-1:0]  res_in, res_ff;

   // Pick the coefficient; the output gain rounds at its own point
   always_comb begin
      unique case (coef_sel)
         COEF_STEP:  coef = cfg.step_scale;
         COEF_X:     coef = cfg.coef_x;
         COEF_POINT: coef = cfg.coef_point;
         COEF_GAIN:  coef = cfg.out_gain;
         default:    coef = cfg.step_scale;
      endcase
   end

   assign gain_in = (coef_sel == COEF_GAIN);
   assign coef_s  = {1'b0, coef};
   assign prod_in = opa * coef_s;

   // Add half an LSB, then shift arithmetically
   always_comb begin
      biased  = prod_ff + (gain_ff ? PROD_BITS'(HALF_GAIN) : PROD_BITS'(HALF_FRAC));
      shifted = gain_ff ? (biased >>> GAIN_FRAC) : (biased >>> FRAC_BITS);
      res_in  = shifted[RES_BITS-1:0];
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      gain_ff <= gain_in;
      res_ff  <= res_in;
   end

endmodule

>>> hdl/audio_emphasis_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_emphasis_filter
// Fixed-point 50/15 us style emphasis filter for signed PCM samples.
// ---------------------------------------------------------------------------
// Takes one request per sample and returns one result per sample. After
// acceptance it runs the step computation, N sub-steps (N is substeps
// clamped to MAX_SUBSTEPS, 8 at reset) and the output gain. A sub-step is
// an advance and a difference step, then three dependent multiply-and-round
// passes through the single shared multiplier (operand, product, rounding);
// the step computation and output gain take one pass each. A finished result
// waits in the output register, so the next request is accepted while the
// previous result is still pending. The user writes configuration over the
// APB-style port while the block is idle; the block does not enforce it.
module audio_emphasis_filter #(
   parameter int MAX_SUBSTEPS = aef_pkg::MAX_SUBSTEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  aef_pkg::aef_req_type                 req_data,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output aef_pkg::aef_rsp_type                 rsp_data,
   // Configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [aef_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [aef_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [aef_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import aef_pkg::*;

   localparam int CW = $clog2(MAX_SUBSTEPS + 1);
   localparam int NW = (CW > SUBSTEPS_BITS) ? CW : SUBSTEPS_BITS;

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_MSTEP = 20'h00002,
      ST_WSTEP = 20'h00004,
      ST_RSTEP = 20'h00008,
      ST_ADV   = 20'h00010,
      ST_DIFF  = 20'h00020,
      ST_MK    = 20'h00040,
      ST_WK    = 20'h00080,
      ST_CK    = 20'h00100,
      ST_MC    = 20'h00200,
      ST_WC    = 20'h00400,
      ST_CC    = 20'h00800,
      ST_MF    = 20'h01000,
      ST_WF    = 20'h02000,
      ST_CF    = 20'h04000,
      ST_OPREP = 20'h08000,
      ST_OMUL  = 20'h10000,
      ST_WOUT  = 20'h20000,
      ST_SUM   = 20'h40000,
      ST_OUT   = 20'h80000
   } state_type;

   aef_cfg_type  cfg;
   coef_sel_type coef_sel;

   state_type                    state_ff, state_in;
   logic signed [STATE_BITS-1:0] h_ff, h_in;
   logic signed [STATE_BITS-1:0] f_ff, f_in;
   logic signed [OPA_BITS-1:0]   step_ff, step_in;
   logic signed [OPA_BITS-1:0]   opa_ff, opa_in;
   logic signed [OPA_BITS-1:0]   d_ff, d_in;
   logic signed [ACC_BITS-1:0]   y_ff, y_in;
   logic        [CW-1:0]         cnt_ff, cnt_in;
   logic                         be_ff, be_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   aef_rsp_type                  rsp_data_ff, rsp_data_in;

   logic signed [RES_BITS-1:0]   res;
   logic signed [ACC_BITS-1:0]   h_x, f_x, r_x, acc;
   logic signed [STATE_BITS-1:0] target;
   logic        [NW-1:0]         sub_w, nsteps;

   aef_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aef_mul_unit u_mul (
      .clock    (clock),
      .cfg      (cfg),
      .coef_sel (coef_sel),
      .opa      (opa_ff),
      .res      (res)
   );

   assign h_x    = ext_state(h_ff);
   assign f_x    = ext_state(f_ff);
   assign r_x    = ext_res(res);
   assign target = {req_data.sample_in, {FRAC_BITS{1'b0}}};

   // Clamp the sub-step count to MAX_SUBSTEPS
   assign sub_w  = NW'(cfg.substeps);
   assign nsteps = (sub_w > NW'(MAX_SUBSTEPS)) ? NW'(MAX_SUBSTEPS) : sub_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      f_in         = f_ff;
      step_in      = step_ff;
      opa_in       = opa_ff;
      d_in         = d_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      be_in        = be_ff;
      coef_sel     = COEF_STEP;
      acc          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         // Take a request: form the distance to the new sample
         ST_IDLE: begin
            if (req_valid) begin
               acc      = ext_state(target) - h_x;
               opa_in   = acc[OPA_BITS-1:0];
               be_in    = req_data.block_end;
               state_in = ST_MSTEP;
            end
         end
         ST_MSTEP: begin
            coef_sel = COEF_STEP;
            state_in = ST_WSTEP;
         end
         ST_WSTEP: state_in = ST_RSTEP;
         // Hold the per-sub-step increment and load the counter
         ST_RSTEP: begin
            step_in  = r_x[OPA_BITS-1:0];
            cnt_in   = nsteps[CW-1:0];
            state_in = (nsteps == '0) ? ST_OPREP : ST_ADV;
         end
         // Advance the held input
         ST_ADV: begin
            acc      = h_x + ext_opa(step_ff);
            h_in     = sat_state(acc);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            acc      = h_x - f_x;
            opa_in   = acc[OPA_BITS-1:0];
            d_in     = acc[OPA_BITS-1:0];
            state_in = ST_MK;
         end
         ST_MK: begin
            coef_sel = COEF_X;
            state_in = ST_WK;
         end
         ST_WK: state_in = ST_CK;
         ST_CK: begin
            opa_in   = r_x[OPA_BITS-1:0];
            state_in = ST_MC;
         end
         ST_MC: begin
            coef_sel = COEF_POINT;
            state_in = ST_WC;
         end
         ST_WC: state_in = ST_CC;
         // Corrected integrator input
         ST_CC: begin
            acc      = ext_opa(d_ff) - r_x;
            opa_in   = acc[OPA_BITS-1:0];
            state_in = ST_MF;
         end
         ST_MF: begin
            coef_sel = COEF_X;
            state_in = ST_WF;
         end
         ST_WF: state_in = ST_CF;
         // Update the filter state and count the sub-step
         ST_CF: begin
            acc      = f_x + r_x;
            f_in     = sat_state(acc);
            cnt_in   = cnt_ff - CW'(1);
            state_in = (cnt_ff == CW'(1)) ? ST_OPREP : ST_ADV;
         end
         ST_OPREP: begin
            acc      = cfg.mode ? (h_x - f_x) : h_x;
            opa_in   = acc[OPA_BITS-1:0];
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            coef_sel = COEF_GAIN;
            state_in = ST_WOUT;
         end
         ST_WOUT: state_in = ST_SUM;
         ST_SUM: begin
            y_in     = (cfg.mode ? h_x : f_x) + r_x;
            state_in = ST_OUT;
         end
         // Drop the result into the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sample_out    = sat_sample(rnd_frac(y_ff));
               rsp_data_in.block_end_out = be_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= '0;
         f_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         f_ff         <= f_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      opa_ff      <= opa_in;
      d_ff        <= d_in;
      y_ff        <= y_in;
      be_ff       <= be_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> hdl/aef_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aef_checker
// Port-level checks of the emphasis filter handshakes, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aef_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input aef_pkg::aef_rsp_type rsp_data
);

   // No result survives reset
   `AEF_ASSERT_NR(a_rsp_cleared, clock, reset |=> !rsp_valid, "result valid after reset")

   // One request at a time: busy straight after acceptance
   `AEF_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "ready right after a request")

   // A new result is only produced while the block is busy
   `AEF_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result appeared while idle")

   // A stalled result holds
   `AEF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind audio_emphasis_filter aef_checker u_aef_checker (.*);
